// ===== rtl/vmb_pkg.sv =====
// ============================================================================
// vmb_pkg: shared types and constants for the 2D view matrix builder
// Widths, angle constants, the arctangent table and the structures that
// travel between the pipeline parts.
// ============================================================================
package vmb_pkg;

    // CORDIC iteration count (8 to 24).
    localparam int CORD_STEPS = 16;

    // Field and datapath widths.
    localparam int ANG_W  = 26;   // angle, Q9.16 degrees
    localparam int XY_W   = 34;   // CORDIC x and y, Q2.30 with headroom
    localparam int C_W    = 18;   // rounded cosine and sine, Q16
    localparam int EXT_W  = 17;   // extents and edge sums
    localparam int ZOOM_W = 24;   // zoom, unsigned Q8.16
    localparam int MAG_W  = 16;   // extent magnitude, divisor
    localparam int P_W    = 36;   // edge sum times cosine or sine
    localparam int U_W    = 37;   // sum of two such products
    localparam int ZC_W   = 43;   // zoom times cosine or sine
    localparam int HALF_W = 19;   // half of a split product operand
    localparam int PU_W   = 44;   // zoom times one half
    localparam int NUM_W  = 60;   // full numerator
    localparam int DIVN_W = 44;   // dividend after the fixed 2^16 scale
    localparam int Q_W    = 32;   // quotient bits
    localparam int LANES  = 6;    // one divider per matrix entry

    localparam logic signed [ANG_W-1:0] DEG360 = ANG_W'(23592960);
    localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(11796480);
    localparam logic signed [ANG_W-1:0] DEG90  = ANG_W'(5898240);
    localparam logic signed [XY_W-1:0]  CORD_X0 = XY_W'(652032874);
    localparam logic signed [XY_W-1:0]  CORD_RND = XY_W'(8192);

    // Viewport geometry that rides along with the angle.
    typedef struct packed {
        logic signed [EXT_W-1:0] w;
        logic signed [EXT_W-1:0] h;
        logic signed [EXT_W-1:0] sx;
        logic signed [EXT_W-1:0] sy;
        logic [ZOOM_W-1:0]       zoom;
        logic                    flip;
        logic                    bad;
    } geom_t;

    // Extent magnitudes and signs used while the numerators are formed.
    typedef struct packed {
        logic [MAG_W-1:0] wm;
        logic [MAG_W-1:0] hm;
        logic             wn;
        logic             hn;
        logic             flip;
        logic             bad;
    } num_side_t;

    // One divider lane's operands.
    typedef struct packed {
        logic [DIVN_W-1:0] num;
        logic [MAG_W-1:0]  den;
        logic              neg;
        logic              kill;
    } lane_in_t;

    // Arctangent of 2^-i in Q16 degrees.
    function automatic logic [22:0] atan_q16(input int unsigned idx);
        logic [22:0] v;
        case (idx)
            0:       v = 23'd2949120;
            1:       v = 23'd1740967;
            2:       v = 23'd919879;
            3:       v = 23'd466945;
            4:       v = 23'd234379;
            5:       v = 23'd117304;
            6:       v = 23'd58666;
            7:       v = 23'd29335;
            8:       v = 23'd14668;
            9:       v = 23'd7334;
            10:      v = 23'd3667;
            11:      v = 23'd1833;
            12:      v = 23'd917;
            13:      v = 23'd458;
            14:      v = 23'd229;
            15:      v = 23'd115;
            16:      v = 23'd57;
            17:      v = 23'd29;
            18:      v = 23'd14;
            19:      v = 23'd7;
            20:      v = 23'd4;
            21:      v = 23'd2;
            22:      v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/view_matrix_builder_2d_core.sv =====
// ============================================================================
// view_matrix_builder_2d_core: 2D orthographic view-projection matrix rows
// Builds the top two rows of a view-projection matrix from a viewport,
// rotation, zoom and vertical flip, in signed Q16.16 with saturation.
//
//   Channel  Direction  Word contents
//   s_axis   in         camera description (see s_tdata)
//   m_axis   out        six matrix entries and the bad extent flag
//
// A word is accepted every cycle while the output side takes words.
// Depth is set by the CORDIC stages, numerator stages and bit-per-stage dividers.
// The whole pipeline holds when a finished word waits at the output.
// Reset clears the valid bits only; the block keeps no state between words.
// ============================================================================
module view_matrix_builder_2d_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // view_left[15:0], view_right[31:16], view_top[47:32],
    // view_bottom[63:48], rotation_deg[89:64], zoom[113:90], flip_y[114]
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m00[31:0], m01[63:32], m02[95:64], m10[127:96], m11[159:128],
    // m12[191:160], bad_extent[192]
    output logic [199:0] m_tdata
);
    import vmb_pkg::*;

    logic en;

    // The pipeline advances unless a word is waiting at the output.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Viewport extents and edge sums.
    logic signed [15:0]      l_in, r_in, t_in, b_in;
    logic signed [ANG_W-1:0] theta_in;
    geom_t                   geom_in;

    assign l_in     = s_tdata[15:0];
    assign r_in     = s_tdata[31:16];
    assign t_in     = s_tdata[47:32];
    assign b_in     = s_tdata[63:48];
    assign theta_in = s_tdata[89:64];

    always_comb
    begin
        geom_in.w    = EXT_W'(r_in) - EXT_W'(l_in);
        geom_in.h    = EXT_W'(t_in) - EXT_W'(b_in);
        geom_in.sx   = EXT_W'(l_in) + EXT_W'(r_in);
        geom_in.sy   = EXT_W'(t_in) + EXT_W'(b_in);
        geom_in.zoom = s_tdata[113:90];
        geom_in.flip = s_tdata[114];
        geom_in.bad  = (r_in == l_in) || (t_in == b_in);
    end

    // Cosine and sine.
    logic                  cord_valid;
    logic signed [C_W-1:0] cos_q16, sin_q16;
    geom_t                 cord_geom;

    vmb_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .theta     (theta_in),
        .in_geom   (geom_in),
        .out_valid (cord_valid),
        .cos_q16   (cos_q16),
        .sin_q16   (sin_q16),
        .out_geom  (cord_geom)
    );

    // Numerators.
    logic     num_valid;
    lane_in_t lanes [LANES];

    vmb_numer u_numer (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cord_valid),
        .cos_q16   (cos_q16),
        .sin_q16   (sin_q16),
        .in_geom   (cord_geom),
        .out_valid (num_valid),
        .lanes     (lanes)
    );

    // One divider per entry; the last stage is the output register.
    logic [LANES-1:0]      lane_valid;
    logic [LANES-1:0]      lane_kill;
    logic signed [Q_W-1:0] lane_res [LANES];

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        vmb_div u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (num_valid),
            .op        (lanes[k]),
            .out_valid (lane_valid[k]),
            .out_kill  (lane_kill[k]),
            .result    (lane_res[k])
        );
    end

    assign m_tvalid = lane_valid[0];
    assign m_tdata  = {7'b0, lane_kill[0], lane_res[5], lane_res[4], lane_res[3],
                       lane_res[2], lane_res[1], lane_res[0]};

`ifndef NO_ASSERTIONS
    // A zero extent gives an all-zero matrix.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[192] |-> m_tdata[191:0] == '0)
        else $error("bad extent word carries nonzero entries");

    // No word enters while a finished word waits.
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted during an output stall");

    // All divider lanes run in lockstep.
    a_lanes_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(lane_valid) == 0 || lane_valid == '1)
        else $error("divider lanes out of step");

    a_lanes_kill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($countones(lane_kill) == 0 || lane_kill == '1))
        else $error("divider lanes disagree on the bad extent flag");
`endif

endmodule

// ===== rtl/vmb_cordic.sv =====
// ============================================================================
// vmb_cordic: angle reduction and pipelined CORDIC
// Reduces the angle into [-90,90] degrees over two stages, runs one CORDIC
// iteration per stage and rounds cosine and sine to Q16.
// ============================================================================
module vmb_cordic (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [vmb_pkg::ANG_W-1:0] theta,
    input  vmb_pkg::geom_t                in_geom,
    output logic                          out_valid,
    output logic signed [vmb_pkg::C_W-1:0] cos_q16,
    output logic signed [vmb_pkg::C_W-1:0] sin_q16,
    output vmb_pkg::geom_t                out_geom
);
    import vmb_pkg::*;

    localparam int NST = CORD_STEPS + 3;

    logic                    valid_reg [NST];
    geom_t                   geom_reg  [NST];
    logic                    flipq_reg [NST];
    logic signed [ANG_W-1:0] r1_reg;
    logic signed [XY_W-1:0]  x_reg [CORD_STEPS+1:1];
    logic signed [XY_W-1:0]  y_reg [CORD_STEPS+1:1];
    logic signed [ANG_W-1:0] z_reg [CORD_STEPS+1:1];
    logic signed [C_W-1:0]   c_reg;
    logic signed [C_W-1:0]   s_reg;

    // Valid bits move with the data whenever the pipeline advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < NST; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // Geometry side band.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geom_reg[0] <= in_geom;
            for (int k = 1; k < NST; k++)
            begin
                geom_reg[k] <= geom_reg[k-1];
            end
        end
    end

    // First fold into [-180,180), then into [-90,90] with a half-turn flag.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (theta >= DEG180)
            begin
                r1_reg <= theta - DEG360;
            end
            else if (theta < -DEG180)
            begin
                r1_reg <= theta + DEG360;
            end
            else
            begin
                r1_reg <= theta;
            end
            flipq_reg[0] <= 1'b0;
            x_reg[1] <= CORD_X0;
            y_reg[1] <= '0;
            if (r1_reg > DEG90)
            begin
                z_reg[1]     <= r1_reg - DEG180;
                flipq_reg[1] <= 1'b1;
            end
            else if (r1_reg < -DEG90)
            begin
                z_reg[1]     <= r1_reg + DEG180;
                flipq_reg[1] <= 1'b1;
            end
            else
            begin
                z_reg[1]     <= r1_reg;
                flipq_reg[1] <= 1'b0;
            end
            for (int k = 2; k < NST; k++)
            begin
                flipq_reg[k] <= flipq_reg[k-1];
            end
        end
    end

    // One rotation step per stage.
    for (genvar i = 0; i < CORD_STEPS; i++)
    begin : g_step
        logic signed [XY_W-1:0]  dx;
        logic signed [XY_W-1:0]  dy;
        logic signed [ANG_W-1:0] da;

        assign dx = x_reg[i+1] >>> i;
        assign dy = y_reg[i+1] >>> i;
        assign da = ANG_W'(atan_q16(i));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[i+1] >= 0)
                begin
                    x_reg[i+2] <= x_reg[i+1] - dy;
                    y_reg[i+2] <= y_reg[i+1] + dx;
                    z_reg[i+2] <= z_reg[i+1] - da;
                end
                else
                begin
                    x_reg[i+2] <= x_reg[i+1] + dy;
                    y_reg[i+2] <= y_reg[i+1] - dx;
                    z_reg[i+2] <= z_reg[i+1] + da;
                end
            end
        end
    end

    // Round Q2.30 to Q16 and undo the half-turn fold.
    logic signed [XY_W-1:0] xr;
    logic signed [XY_W-1:0] yr;

    assign xr = (x_reg[CORD_STEPS+1] + CORD_RND) >>> 14;
    assign yr = (y_reg[CORD_STEPS+1] + CORD_RND) >>> 14;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg <= flipq_reg[NST-2] ? C_W'(-xr) : C_W'(xr);
            s_reg <= flipq_reg[NST-2] ? C_W'(-yr) : C_W'(yr);
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign out_geom  = geom_reg[NST-1];
    assign cos_q16   = c_reg;
    assign sin_q16   = s_reg;

endmodule

// ===== rtl/vmb_numer.sv =====
// ============================================================================
// vmb_numer: numerator builder
// Forms the six exact numerators from zoom, edge sums, cosine and sine,
// takes their magnitudes and signs, and applies the rounding offset.
// ============================================================================
module vmb_numer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [vmb_pkg::C_W-1:0] cos_q16,
    input  logic signed [vmb_pkg::C_W-1:0] sin_q16,
    input  vmb_pkg::geom_t                 in_geom,
    output logic                           out_valid,
    output vmb_pkg::lane_in_t              lanes [vmb_pkg::LANES]
);
    import vmb_pkg::*;

    localparam int NST = 6;

    logic valid_reg [NST];

    logic signed [P_W-1:0]    p1_reg, q1_reg, r1_reg, t1_reg;
    logic signed [ZC_W-1:0]   zc1_reg, zs1_reg;
    logic [ZOOM_W-1:0]        zoom1_reg, zoom2_reg;
    num_side_t                side1_reg, side2_reg, side3_reg, side4_reg, side5_reg;
    logic signed [U_W-1:0]    u2_reg, v2_reg;
    logic signed [ZC_W-1:0]   zc2_reg, zs2_reg, zc3_reg, zs3_reg, zc4_reg, zs4_reg;
    logic signed [PU_W-1:0]   uh3_reg, ul3_reg, vh3_reg, vl3_reg;
    logic signed [NUM_W-1:0]  zu4_reg, zv4_reg;
    logic [NUM_W-1:0]         mzc5_reg, mzs5_reg, mzu5_reg, mzv5_reg;
    logic [LANES-1:0]         neg5_reg;
    lane_in_t                 lanes_reg [LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < NST; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // Stage 1: products of edge sums and zoom with cosine and sine.
    logic signed [ZOOM_W:0] zoom_s;
    num_side_t              side_in;

    assign zoom_s = $signed({1'b0, in_geom.zoom});

    always_comb
    begin
        side_in.wm   = in_geom.w[EXT_W-1] ? MAG_W'(-in_geom.w) : MAG_W'(in_geom.w);
        side_in.hm   = in_geom.h[EXT_W-1] ? MAG_W'(-in_geom.h) : MAG_W'(in_geom.h);
        side_in.wn   = in_geom.w[EXT_W-1];
        side_in.hn   = in_geom.h[EXT_W-1];
        side_in.flip = in_geom.flip;
        side_in.bad  = in_geom.bad;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg    <= P_W'(in_geom.sx) * P_W'(cos_q16);
            q1_reg    <= P_W'(in_geom.sy) * P_W'(sin_q16);
            r1_reg    <= P_W'(in_geom.sx) * P_W'(sin_q16);
            t1_reg    <= P_W'(in_geom.sy) * P_W'(cos_q16);
            zc1_reg   <= ZC_W'(zoom_s) * ZC_W'(cos_q16);
            zs1_reg   <= ZC_W'(zoom_s) * ZC_W'(sin_q16);
            zoom1_reg <= in_geom.zoom;
            side1_reg <= side_in;
        end
    end

    // Stage 2: sum and difference of the edge-sum products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u2_reg    <= U_W'(p1_reg) + U_W'(q1_reg);
            v2_reg    <= U_W'(r1_reg) - U_W'(t1_reg);
            zc2_reg   <= zc1_reg;
            zs2_reg   <= zs1_reg;
            zoom2_reg <= zoom1_reg;
            side2_reg <= side1_reg;
        end
    end

    // Stage 3: zoom times each half of the combinations.
    logic signed [ZOOM_W:0]  zoom2_s;
    logic signed [HALF_W-1:0] uh, ul, vh, vl;

    assign zoom2_s = $signed({1'b0, zoom2_reg});
    assign uh = u2_reg[U_W-1:U_W-HALF_W];
    assign ul = $signed({1'b0, u2_reg[U_W-HALF_W-1:0]});
    assign vh = v2_reg[U_W-1:U_W-HALF_W];
    assign vl = $signed({1'b0, v2_reg[U_W-HALF_W-1:0]});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            uh3_reg   <= PU_W'(zoom2_s) * PU_W'(uh);
            ul3_reg   <= PU_W'(zoom2_s) * PU_W'(ul);
            vh3_reg   <= PU_W'(zoom2_s) * PU_W'(vh);
            vl3_reg   <= PU_W'(zoom2_s) * PU_W'(vl);
            zc3_reg   <= zc2_reg;
            zs3_reg   <= zs2_reg;
            side3_reg <= side2_reg;
        end
    end

    // Stage 4: recombine the split products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zu4_reg   <= (NUM_W'(uh3_reg) <<< (U_W - HALF_W)) + NUM_W'(ul3_reg);
            zv4_reg   <= (NUM_W'(vh3_reg) <<< (U_W - HALF_W)) + NUM_W'(vl3_reg);
            zc4_reg   <= zc3_reg;
            zs4_reg   <= zs3_reg;
            side4_reg <= side3_reg;
        end
    end

    // Stage 5: magnitudes and quotient signs.
    logic signed [NUM_W-1:0] zc_e, zs_e;
    logic                    zc_n, zs_n, zu_n, zv_n;

    assign zc_e = NUM_W'(zc4_reg);
    assign zs_e = NUM_W'(zs4_reg);
    assign zc_n = zc4_reg[ZC_W-1];
    assign zs_n = zs4_reg[ZC_W-1];
    assign zu_n = zu4_reg[NUM_W-1];
    assign zv_n = zv4_reg[NUM_W-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mzc5_reg    <= zc_n ? NUM_W'(-zc_e) << 1 : NUM_W'(zc_e) << 1;
            mzs5_reg    <= zs_n ? NUM_W'(-zs_e) << 1 : NUM_W'(zs_e) << 1;
            mzu5_reg    <= zu_n ? NUM_W'(-zu4_reg) : NUM_W'(zu4_reg);
            mzv5_reg    <= zv_n ? NUM_W'(-zv4_reg) : NUM_W'(zv4_reg);
            neg5_reg[0] <= zc_n ^ side4_reg.wn;
            neg5_reg[1] <= zs_n ^ side4_reg.wn;
            neg5_reg[2] <= ~zu_n ^ side4_reg.wn;
            neg5_reg[3] <= zs_n ^ ~side4_reg.flip ^ side4_reg.hn;
            neg5_reg[4] <= zc_n ^ side4_reg.flip ^ side4_reg.hn;
            neg5_reg[5] <= zv_n ^ side4_reg.flip ^ side4_reg.hn;
            side5_reg   <= side4_reg;
        end
    end

    // Stage 6: add half the divisor and drop the fixed 2^16 scale.
    logic [NUM_W-1:0] mag6 [LANES];
    logic [NUM_W:0]   sum6 [LANES];

    always_comb
    begin
        mag6[0] = mzc5_reg;
        mag6[1] = mzs5_reg;
        mag6[2] = mzu5_reg;
        mag6[3] = mzs5_reg;
        mag6[4] = mzc5_reg;
        mag6[5] = mzv5_reg;
        for (int k = 0; k < LANES; k++)
        begin
            if (k < LANES / 2)
            begin
                sum6[k] = {1'b0, mag6[k]} + ((NUM_W+1)'(side5_reg.wm) << 15);
            end
            else
            begin
                sum6[k] = {1'b0, mag6[k]} + ((NUM_W+1)'(side5_reg.hm) << 15);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                lanes_reg[k].num  <= sum6[k][DIVN_W+15:16];
                lanes_reg[k].den  <= (k < LANES / 2) ? side5_reg.wm : side5_reg.hm;
                lanes_reg[k].neg  <= neg5_reg[k];
                lanes_reg[k].kill <= side5_reg.bad;
            end
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign lanes     = lanes_reg;

endmodule

// ===== rtl/vmb_div.sv =====
// ============================================================================
// vmb_div: pipelined divider lane
// Restoring division with one quotient bit per stage, overflow detection,
// sign application and saturation to signed Q16.16.
// ============================================================================
module vmb_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  vmb_pkg::lane_in_t             op,
    output logic                          out_valid,
    output logic                          out_kill,
    output logic signed [vmb_pkg::Q_W-1:0] result
);
    import vmb_pkg::*;

    localparam int NST = Q_W + 2;

    logic             valid_reg [NST];
    logic [MAG_W-1:0] rem_reg   [Q_W+1];
    logic [Q_W-1:0]   ql_reg    [Q_W+1];
    logic [MAG_W-1:0] den_reg   [Q_W+1];
    logic             neg_reg   [Q_W+1];
    logic             ovf_reg   [Q_W+1];
    logic             kill_reg  [Q_W+1];
    logic signed [Q_W-1:0] res_reg;
    logic             kill_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < NST; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // Entry stage: a high part not below the divisor means the quotient
    // does not fit in the quotient width.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= MAG_W'(op.num[DIVN_W-1:Q_W]);
            ql_reg[0]   <= op.num[Q_W-1:0];
            den_reg[0]  <= op.den;
            neg_reg[0]  <= op.neg;
            kill_reg[0] <= op.kill;
            ovf_reg[0]  <= MAG_W'(op.num[DIVN_W-1:Q_W]) >= op.den;
        end
    end

    // One quotient bit per stage; quotient bits shift in behind the dividend.
    for (genvar i = 0; i < Q_W; i++)
    begin : g_bit
        logic [MAG_W:0] trial;
        logic [MAG_W:0] diff;
        logic           ge;

        assign trial = {rem_reg[i], ql_reg[i][Q_W-1]};
        assign diff  = trial - {1'b0, den_reg[i]};
        assign ge    = trial >= {1'b0, den_reg[i]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1]  <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
                ql_reg[i+1]   <= {ql_reg[i][Q_W-2:0], ge};
                den_reg[i+1]  <= den_reg[i];
                neg_reg[i+1]  <= neg_reg[i];
                ovf_reg[i+1]  <= ovf_reg[i];
                kill_reg[i+1] <= kill_reg[i];
            end
        end
    end

    // Sign and saturation; a zero extent forces zero.
    logic [Q_W-1:0] q;
    logic           sat_pos;
    logic           sat_neg;

    assign q       = ql_reg[Q_W];
    assign sat_pos = ovf_reg[Q_W] | q[Q_W-1];
    assign sat_neg = ovf_reg[Q_W] | (q[Q_W-1] & (q[Q_W-2:0] != '0));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kill_out_reg <= kill_reg[Q_W];
            if (kill_reg[Q_W])
            begin
                res_reg <= '0;
            end
            else if (neg_reg[Q_W])
            begin
                res_reg <= sat_neg ? {1'b1, {(Q_W-1){1'b0}}} : $signed(-q);
            end
            else
            begin
                res_reg <= sat_pos ? {1'b0, {(Q_W-1){1'b1}}} : $signed(q);
            end
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign out_kill  = kill_out_reg;
    assign result    = res_reg;

endmodule
